>>> src/lstf_pkg.sv
package lstf_pkg;

    // Result word and output count widths.
    localparam int RES_W     = 32;
    localparam int CNT_OUT_W = 8;

    // Back end datapath: 64-bit sums, 128-bit products and quotient inputs.
    localparam int OP_W        = 64;
    localparam int WIDE_W      = 128;
    localparam int DIGIT_W     = 16;
    localparam int MUL_STEPS   = OP_W / DIGIT_W;
    localparam int SLOPE_SHIFT = 16;

    // Quotient register holds up to twice the cap, the cap itself is 2^40.
    localparam int Q_W = 41;

    localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};
    localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};

    // Status of the track queue between front and back end.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

>>> src/lstf_if.sv
// Point channel: one track point per transaction.
interface lstf_point_if #(parameter int COORD_WIDTH = 24);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic signed [COORD_WIDTH-1:0] coord_z;
    logic                          use_for_xz;
    logic                          use_for_yz;
    logic                          last_point;

    modport source (output valid, coord_x, coord_y, coord_z, use_for_xz, use_for_yz,
                    last_point, input ready);
    modport sink (input valid, coord_x, coord_y, coord_z, use_for_xz, use_for_yz,
                  last_point, output ready);
endinterface

// Result channel: one fitted track per transaction.
interface lstf_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [lstf_pkg::RES_W-1:0]     slope_xz;
    logic signed [lstf_pkg::RES_W-1:0]     intercept_xz;
    logic signed [lstf_pkg::RES_W-1:0]     slope_yz;
    logic signed [lstf_pkg::RES_W-1:0]     intercept_yz;
    logic                                  degenerate_xz;
    logic                                  degenerate_yz;
    logic        [lstf_pkg::CNT_OUT_W-1:0] points_xz;
    logic        [lstf_pkg::CNT_OUT_W-1:0] points_yz;

    modport source (output valid, slope_xz, intercept_xz, slope_yz, intercept_yz,
                    degenerate_xz, degenerate_yz, points_xz, points_yz, input ready);
    modport sink (input valid, slope_xz, intercept_xz, slope_yz, intercept_yz,
                  degenerate_xz, degenerate_yz, points_xz, points_yz, output ready);
endinterface

>>> src/least_squares_track_line_fit.sv
// Least-squares line fitter for tracks: x on z and y on z. The front end takes
// one point per cycle and keeps a count and four sums per fit; the point marked
// last closes the track and hands the sums to a two-entry queue, so the next
// track can be accumulated at once. The back end fits each track on one shared
// sequencer: per fit six 64 by 64 products, 16 bits a cycle, and two rounded
// quotients from a restoring divider, one bit a cycle. Points stall only while
// two finished tracks wait in the queue.
module least_squares_track_line_fit #(
    parameter int MAX_POINTS  = 128,
    parameter int COORD_WIDTH = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lstf_point_if.sink    i_point,
    lstf_result_if.source o_result
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int SA_W  = COORD_WIDTH + CNT_W;
    localparam int SP_W  = (2 * COORD_WIDTH + CNT_W > lstf_pkg::OP_W) ? lstf_pkg::OP_W
                                                                      : 2 * COORD_WIDTH + CNT_W;
    localparam int TRK_W = 2 * (CNT_W + 2 * SA_W + 2 * SP_W);

    logic                q_push, q_pop;
    logic [TRK_W-1:0]    q_in, q_out;
    lstf_pkg::t_q_status q_status;

    lstf_front #(
        .MAX_POINTS  (MAX_POINTS),
        .COORD_WIDTH (COORD_WIDTH),
        .CNT_W       (CNT_W),
        .SA_W        (SA_W),
        .SP_W        (SP_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_point    (i_point),
        .i_q_status (q_status),
        .o_push     (q_push),
        .o_track    (q_in)
    );

    lstf_queue #(
        .DATA_W (TRK_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (q_in),
        .i_pop    (q_pop),
        .o_data   (q_out),
        .o_status (q_status)
    );

    lstf_back #(
        .CNT_W (CNT_W),
        .SA_W  (SA_W),
        .SP_W  (SP_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_track       (q_out),
        .i_track_valid (!q_status.empty),
        .o_track_ready (q_pop),
        .o_result      (o_result)
    );

    // A closed track is never pushed into a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_status.full)
        else $error("track pushed into full queue");

    // A last-point transaction leaves a track waiting in the queue.
    a_last_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_point.valid && i_point.ready && i_point.last_point) |=> !q_status.empty)
        else $error("closed track missing from queue");

    // Degenerate fits report zero slope and intercept.
    a_deg_xz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.degenerate_xz) |->
            (o_result.slope_xz == '0 && o_result.intercept_xz == '0))
        else $error("degenerate xz fit with nonzero result");

    a_deg_yz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.degenerate_yz) |->
            (o_result.slope_yz == '0 && o_result.intercept_yz == '0))
        else $error("degenerate yz fit with nonzero result");

endmodule

>>> src/lstf_front.sv
module lstf_front #(
    parameter int MAX_POINTS  = 128,
    parameter int COORD_WIDTH = 24,
    parameter int CNT_W       = 8,
    parameter int SA_W        = 32,
    parameter int SP_W        = 56,
    localparam int FIT_W      = CNT_W + 2 * SA_W + 2 * SP_W,
    localparam int TRK_W      = 2 * FIT_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    lstf_point_if.sink          i_point,
    input  lstf_pkg::t_q_status i_q_status,
    output logic                o_push,
    output logic [TRK_W-1:0]    o_track
);

    logic signed [COORD_WIDTH-1:0]   cx, cy, cz;
    logic signed [2*COORD_WIDTH-1:0] pzz, pxz, pyz;
    logic                            accept, take_xz, take_yz;

    logic        [CNT_W-1:0] r_cnt_xz, n_cnt_xz, r_cnt_yz, n_cnt_yz;
    logic signed [SA_W-1:0]  r_sx, n_sx, r_szx, n_szx, r_sy, n_sy, r_szy, n_szy;
    logic signed [SP_W-1:0]  r_szzx, n_szzx, r_sxz, n_sxz, r_szzy, n_szzy, r_syz, n_syz;

    assign cx = i_point.coord_x;
    assign cy = i_point.coord_y;
    assign cz = i_point.coord_z;

    // A point is taken whenever the queue can hold a finished track.
    assign i_point.ready = !i_q_status.full;
    assign accept        = i_point.valid && i_point.ready;

    // A fit stops growing once it holds the maximum number of points.
    assign take_xz = i_point.use_for_xz && (r_cnt_xz < CNT_W'(MAX_POINTS));
    assign take_yz = i_point.use_for_yz && (r_cnt_yz < CNT_W'(MAX_POINTS));

    assign pzz = cz * cz;
    assign pxz = cx * cz;
    assign pyz = cy * cz;

    // Running sums including the current point.
    always_comb begin
        n_cnt_xz = r_cnt_xz;
        n_sx     = r_sx;
        n_szx    = r_szx;
        n_szzx   = r_szzx;
        n_sxz    = r_sxz;
        n_cnt_yz = r_cnt_yz;
        n_sy     = r_sy;
        n_szy    = r_szy;
        n_szzy   = r_szzy;
        n_syz    = r_syz;
        if (take_xz) begin
            n_cnt_xz = r_cnt_xz + CNT_W'(1);
            n_sx     = r_sx + SA_W'(cx);
            n_szx    = r_szx + SA_W'(cz);
            n_szzx   = r_szzx + SP_W'(pzz);
            n_sxz    = r_sxz + SP_W'(pxz);
        end
        if (take_yz) begin
            n_cnt_yz = r_cnt_yz + CNT_W'(1);
            n_sy     = r_sy + SA_W'(cy);
            n_szy    = r_szy + SA_W'(cz);
            n_szzy   = r_szzy + SP_W'(pzz);
            n_syz    = r_syz + SP_W'(pyz);
        end
    end

    // The last point hands the completed sums to the queue.
    assign o_push  = accept && i_point.last_point;
    assign o_track = {n_cnt_yz, n_sy, n_szy, n_szzy, n_syz,
                      n_cnt_xz, n_sx, n_szx, n_szzx, n_sxz};

    // Accumulators, cleared at the end of every track.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_cnt_xz <= '0;
            r_sx     <= '0;
            r_szx    <= '0;
            r_szzx   <= '0;
            r_sxz    <= '0;
            r_cnt_yz <= '0;
            r_sy     <= '0;
            r_szy    <= '0;
            r_szzy   <= '0;
            r_syz    <= '0;
        end else if (accept) begin
            r_cnt_xz <= n_cnt_xz;
            r_sx     <= n_sx;
            r_szx    <= n_szx;
            r_szzx   <= n_szzx;
            r_sxz    <= n_sxz;
            r_cnt_yz <= n_cnt_yz;
            r_sy     <= n_sy;
            r_szy    <= n_szy;
            r_szzy   <= n_szzy;
            r_syz    <= n_syz;
        end
    end

endmodule

>>> src/lstf_queue.sv
module lstf_queue #(
    parameter int DATA_W = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [DATA_W-1:0]   i_data,
    input  logic                i_pop,
    output logic [DATA_W-1:0]   o_data,
    output lstf_pkg::t_q_status o_status
);

    // Two-entry queue of finished track sums.
    logic [DATA_W-1:0] r_mem [2];
    logic              r_wr, r_rd;
    logic [1:0]        r_cnt;

    assign o_data          = r_mem[r_rd];
    assign o_status.full   = (r_cnt == 2'd2);
    assign o_status.empty  = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

>>> src/lstf_back.sv
module lstf_back #(
    parameter int CNT_W  = 8,
    parameter int SA_W   = 32,
    parameter int SP_W   = 56,
    localparam int FIT_W = CNT_W + 2 * SA_W + 2 * SP_W,
    localparam int TRK_W = 2 * FIT_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [TRK_W-1:0] i_track,
    input  logic             i_track_valid,
    output logic             o_track_ready,
    lstf_result_if.source    o_result
);

    localparam int OP_W   = lstf_pkg::OP_W;
    localparam int WIDE_W = lstf_pkg::WIDE_W;
    localparam int DIG_W  = lstf_pkg::DIGIT_W;
    localparam int RES_W  = lstf_pkg::RES_W;
    localparam int Q_W    = lstf_pkg::Q_W;
    localparam int DSTEP_W = $clog2(WIDE_W);
    localparam int MSTEP_W = $clog2(lstf_pkg::MUL_STEPS);

    // Product steps of one fit.
    localparam logic [2:0] OP_N_ZZ  = 3'd0;
    localparam logic [2:0] OP_Z_Z   = 3'd1;
    localparam logic [2:0] OP_N_AZ  = 3'd2;
    localparam logic [2:0] OP_A_Z   = 3'd3;
    localparam logic [2:0] OP_ZZ_A  = 3'd4;
    localparam logic [2:0] OP_Z_AZ  = 3'd5;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MLOAD = 9'b000000010,
        S_MUL   = 9'b000000100,
        S_MACC  = 9'b000001000,
        S_CHECK = 9'b000010000,
        S_DLOAD = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_DFIN  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state;
    logic   r_fit, r_div_sel;
    logic [2:0]         r_op;
    logic [MSTEP_W-1:0] r_mstep;
    logic [DSTEP_W-1:0] r_dstep;

    logic [OP_W-1:0]   r_ma, r_mb;
    logic              r_mneg;
    logic [WIDE_W-1:0] r_acc, r_den, r_nums, r_numi;

    logic [WIDE_W-1:0] r_dmag, r_rem;
    logic              r_dneg;
    logic [Q_W-1:0]    r_q;

    logic [RES_W-1:0] r_slope [2];
    logic [RES_W-1:0] r_icpt  [2];
    logic             r_deg   [2];
    logic             r_out_valid;

    // Fields of the selected fit from the queue head.
    logic [FIT_W-1:0] fit_v;
    logic [OP_W-1:0]  f_n, f_sa, f_sz, f_szz, f_saz;
    logic [OP_W-1:0]  op_a, op_b;

    assign fit_v = i_track[r_fit*FIT_W +: FIT_W];
    assign f_n   = OP_W'(fit_v[FIT_W-1 -: CNT_W]);
    assign f_sa  = OP_W'($signed(fit_v[2*SP_W+SA_W +: SA_W]));
    assign f_sz  = OP_W'($signed(fit_v[2*SP_W +: SA_W]));
    assign f_szz = OP_W'($signed(fit_v[SP_W +: SP_W]));
    assign f_saz = OP_W'($signed(fit_v[0 +: SP_W]));

    // Operand pair for each product of the fit.
    always_comb begin
        unique case (r_op)
            OP_N_ZZ: begin op_a = f_n;   op_b = f_szz; end
            OP_Z_Z:  begin op_a = f_sz;  op_b = f_sz;  end
            OP_N_AZ: begin op_a = f_n;   op_b = f_saz; end
            OP_A_Z:  begin op_a = f_sa;  op_b = f_sz;  end
            OP_ZZ_A: begin op_a = f_szz; op_b = f_sa;  end
            OP_Z_AZ: begin op_a = f_sz;  op_b = f_saz; end
            default: begin op_a = '0;    op_b = '0;    end
        endcase
    end

    // One 64 by 16 partial product per multiply step.
    logic [OP_W+DIG_W-1:0] part;
    assign part = r_ma * r_mb[OP_W-1 -: DIG_W];

    // Restoring division step.
    logic [WIDE_W-1:0] d_shift;
    logic              d_sub;
    assign d_shift = {r_rem[WIDE_W-2:0], r_dmag[WIDE_W-1]};
    assign d_sub   = r_rem[WIDE_W-1] || (d_shift >= r_den);

    // Rounding and saturation of the finished quotient.
    logic           round_up;
    logic [Q_W:0]   q_fin;
    logic [RES_W-1:0] div_res;
    assign round_up = {r_rem, 1'b0} >= {1'b0, r_den};
    assign q_fin    = {1'b0, r_q} + (Q_W+1)'(round_up);

    always_comb begin
        if (r_dneg) begin
            if (q_fin > (Q_W+1)'(64'd1 << (RES_W-1))) begin
                div_res = lstf_pkg::RES_MIN;
            end else begin
                div_res = RES_W'((Q_W+1)'(0) - q_fin);
            end
        end else begin
            if (q_fin > (Q_W+1)'(lstf_pkg::RES_MAX)) begin
                div_res = lstf_pkg::RES_MAX;
            end else begin
                div_res = q_fin[RES_W-1:0];
            end
        end
    end

    // Dividend for the current quotient: scaled slope numerator or intercept numerator.
    logic [WIDE_W-1:0] div_num;
    assign div_num = r_div_sel ? r_numi
                               : {r_nums[WIDE_W-1-lstf_pkg::SLOPE_SHIFT:0],
                                  {lstf_pkg::SLOPE_SHIFT{1'b0}}};

    logic out_free;
    assign out_free      = !r_out_valid || o_result.ready;
    assign o_track_ready = (r_state == S_OUT) && out_free;

    // Sequencer over both fits: six products, a degeneracy check, two quotients unless degenerate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fit     <= 1'b0;
            r_op      <= OP_N_ZZ;
            r_div_sel <= 1'b0;
            r_mstep   <= '0;
            r_dstep   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_fit <= 1'b0;
                    r_op  <= OP_N_ZZ;
                    if (i_track_valid) begin
                        r_state <= S_MLOAD;
                    end
                end
                S_MLOAD: begin
                    r_ma    <= op_a[OP_W-1] ? OP_W'(0) - op_a : op_a;
                    r_mb    <= op_b[OP_W-1] ? OP_W'(0) - op_b : op_b;
                    r_mneg  <= op_a[OP_W-1] ^ op_b[OP_W-1];
                    r_acc   <= '0;
                    r_mstep <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_acc   <= {r_acc[WIDE_W-DIG_W-1:0], {DIG_W{1'b0}}} + WIDE_W'(part);
                    r_mb    <= {r_mb[OP_W-DIG_W-1:0], {DIG_W{1'b0}}};
                    r_mstep <= r_mstep + MSTEP_W'(1);
                    if (r_mstep == MSTEP_W'(lstf_pkg::MUL_STEPS - 1)) begin
                        r_state <= S_MACC;
                    end
                end
                S_MACC: begin
                    // Even steps load a term, odd steps subtract the second term.
                    unique case (r_op)
                        OP_N_ZZ: r_den  <= r_mneg ? WIDE_W'(0) - r_acc : r_acc;
                        OP_Z_Z:  r_den  <= r_mneg ? r_den + r_acc : r_den - r_acc;
                        OP_N_AZ: r_nums <= r_mneg ? WIDE_W'(0) - r_acc : r_acc;
                        OP_A_Z:  r_nums <= r_mneg ? r_nums + r_acc : r_nums - r_acc;
                        OP_ZZ_A: r_numi <= r_mneg ? WIDE_W'(0) - r_acc : r_acc;
                        OP_Z_AZ: r_numi <= r_mneg ? r_numi + r_acc : r_numi - r_acc;
                        default: r_den  <= r_den;
                    endcase
                    if (r_op == OP_Z_AZ) begin
                        r_state <= S_CHECK;
                    end else begin
                        r_op    <= r_op + 3'd1;
                        r_state <= S_MLOAD;
                    end
                end
                S_CHECK: begin
                    // No points, one point or constant z leave a denominator of zero.
                    r_div_sel <= 1'b0;
                    if (r_den == '0 || r_den[WIDE_W-1]) begin
                        r_deg[r_fit]   <= 1'b1;
                        r_slope[r_fit] <= '0;
                        r_icpt[r_fit]  <= '0;
                        r_op           <= OP_N_ZZ;
                        if (r_fit) begin
                            r_state <= S_OUT;
                        end else begin
                            r_fit   <= 1'b1;
                            r_state <= S_MLOAD;
                        end
                    end else begin
                        r_deg[r_fit] <= 1'b0;
                        r_state      <= S_DLOAD;
                    end
                end
                S_DLOAD: begin
                    r_dneg  <= div_num[WIDE_W-1];
                    r_dmag  <= div_num[WIDE_W-1] ? WIDE_W'(0) - div_num : div_num;
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_dstep <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem   <= d_sub ? d_shift - r_den : d_shift;
                    r_dmag  <= {r_dmag[WIDE_W-2:0], 1'b0};
                    r_q     <= r_q[Q_W-1] ? {1'b1, {(Q_W-1){1'b0}}} : {r_q[Q_W-2:0], d_sub};
                    r_dstep <= r_dstep + DSTEP_W'(1);
                    if (r_dstep == DSTEP_W'(WIDE_W - 1)) begin
                        r_state <= S_DFIN;
                    end
                end
                S_DFIN: begin
                    if (!r_div_sel) begin
                        r_slope[r_fit] <= div_res;
                        r_div_sel      <= 1'b1;
                        r_state        <= S_DLOAD;
                    end else begin
                        r_icpt[r_fit] <= div_res;
                        r_op          <= OP_N_ZZ;
                        if (r_fit) begin
                            r_state <= S_OUT;
                        end else begin
                            r_fit   <= 1'b1;
                            r_state <= S_MLOAD;
                        end
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register; the queue head is released when the result is loaded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_track_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_track_ready) begin
            o_result.slope_xz      <= r_slope[0];
            o_result.intercept_xz  <= r_icpt[0];
            o_result.slope_yz      <= r_slope[1];
            o_result.intercept_yz  <= r_icpt[1];
            o_result.degenerate_xz <= r_deg[0];
            o_result.degenerate_yz <= r_deg[1];
            o_result.points_xz     <= lstf_pkg::CNT_OUT_W'(i_track[FIT_W-1 -: CNT_W]);
            o_result.points_yz     <= lstf_pkg::CNT_OUT_W'(i_track[TRK_W-1 -: CNT_W]);
        end
    end

    assign o_result.valid = r_out_valid;

endmodule

>>> verif/lstf_fit_checker.sv
`timescale 1ns / 1ps

// Watches the point and result channels, predicts every fitted track and
// compares it field by field with what the block returns.
module lstf_fit_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    lstf_point_if  pt,
    lstf_result_if res,
    output int     o_errors,
    output int     o_pending,
    output int     o_results,
    output int     o_degenerate
);

    typedef struct {
        logic signed [lstf_pkg::RES_W-1:0]     slope_xz;
        logic signed [lstf_pkg::RES_W-1:0]     intercept_xz;
        logic signed [lstf_pkg::RES_W-1:0]     slope_yz;
        logic signed [lstf_pkg::RES_W-1:0]     intercept_yz;
        logic                                  degenerate_xz;
        logic                                  degenerate_yz;
        logic        [lstf_pkg::CNT_OUT_W-1:0] points_xz;
        logic        [lstf_pkg::CNT_OUT_W-1:0] points_yz;
    } t_track_fit;

    localparam int TRACK_LIMIT = 128;

    // Running sums of the track being accumulated.
    int unsigned n_xz, n_yz;
    longint      acc_x, acc_zx, acc_zzx, acc_xz;
    longint      acc_y, acc_zy, acc_zzy, acc_yz;

    t_track_fit fit_queue[$];

    // Rounded (ties away from zero) and saturated quotient; den is positive.
    function automatic logic signed [31:0] round_quotient(logic signed [127:0] num,
                                                          logic [127:0] den);
        logic [127:0] mag, q, r;
        logic         neg;
        neg = num[127];
        mag = neg ? -num : num;
        q   = mag / den;
        r   = mag % den;
        if (r >= den - r) q = q + 1;
        if (neg) begin
            if (q > 128'h8000_0000) return lstf_pkg::RES_MIN;
            return -q[31:0];
        end
        if (q > 128'h7FFF_FFFF) return lstf_pkg::RES_MAX;
        return q[31:0];
    endfunction

    // Least-squares slope (Q16.16) and intercept; returns the degenerate flag.
    function automatic logic solve_line(int unsigned n, longint sa, longint sz, longint szz,
                                        longint saz, output logic signed [31:0] slope,
                                        output logic signed [31:0] icpt);
        logic signed [127:0] wn, wsa, wsz, wszz, wsaz, den, num;
        wn    = 128'(n);
        wsa   = 128'(sa);
        wsz   = 128'(sz);
        wszz  = 128'(szz);
        wsaz  = 128'(saz);
        slope = '0;
        icpt  = '0;
        if (n == 0) return 1'b1;
        den = wn * wszz - wsz * wsz;
        if (den <= 0) return 1'b1;
        num   = (wn * wsaz - wsa * wsz) <<< 16;
        slope = round_quotient(num, den);
        icpt  = round_quotient(wszz * wsa - wsz * wsaz, den);
        return 1'b0;
    endfunction

    task automatic compare_field(string name, longint expv, longint actv);
        if (expv !== actv) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
            o_errors++;
        end
    endtask

    assign o_pending = fit_queue.size();

    always @(posedge i_clk) begin
        longint     x, y, z;
        t_track_fit f, e;
        if (!i_rst_n) begin
            n_xz  = 0; n_yz = 0;
            acc_x = 0; acc_zx = 0; acc_zzx = 0; acc_xz = 0;
            acc_y = 0; acc_zy = 0; acc_zzy = 0; acc_yz = 0;
        end else begin
            // Accepted point transaction: update sums, close the track on last.
            if (pt.valid && pt.ready) begin
                x = longint'(pt.coord_x);
                y = longint'(pt.coord_y);
                z = longint'(pt.coord_z);
                if (pt.use_for_xz && n_xz < TRACK_LIMIT) begin
                    n_xz++;
                    acc_x += x; acc_zx += z; acc_zzx += z * z; acc_xz += x * z;
                end
                if (pt.use_for_yz && n_yz < TRACK_LIMIT) begin
                    n_yz++;
                    acc_y += y; acc_zy += z; acc_zzy += z * z; acc_yz += y * z;
                end
                if (pt.last_point) begin
                    f.degenerate_xz = solve_line(n_xz, acc_x, acc_zx, acc_zzx, acc_xz,
                                                 f.slope_xz, f.intercept_xz);
                    f.degenerate_yz = solve_line(n_yz, acc_y, acc_zy, acc_zzy, acc_yz,
                                                 f.slope_yz, f.intercept_yz);
                    f.points_xz = n_xz[7:0];
                    f.points_yz = n_yz[7:0];
                    fit_queue.push_back(f);
                    n_xz  = 0; n_yz = 0;
                    acc_x = 0; acc_zx = 0; acc_zzx = 0; acc_xz = 0;
                    acc_y = 0; acc_zy = 0; acc_zzy = 0; acc_yz = 0;
                end
            end
            // Accepted result transaction: compare with the oldest prediction.
            if (res.valid && res.ready) begin
                o_results++;
                if (fit_queue.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual slope_xz %0d",
                             $time, res.slope_xz);
                    o_errors++;
                end else begin
                    e = fit_queue.pop_front();
                    if (e.degenerate_xz || e.degenerate_yz) o_degenerate++;
                    compare_field("slope_xz", e.slope_xz, res.slope_xz);
                    compare_field("intercept_xz", e.intercept_xz, res.intercept_xz);
                    compare_field("slope_yz", e.slope_yz, res.slope_yz);
                    compare_field("intercept_yz", e.intercept_yz, res.intercept_yz);
                    compare_field("degenerate_xz", e.degenerate_xz, res.degenerate_xz);
                    compare_field("degenerate_yz", e.degenerate_yz, res.degenerate_yz);
                    compare_field("points_xz", e.points_xz, res.points_xz);
                    compare_field("points_yz", e.points_yz, res.points_yz);
                end
            end
        end
    end

    initial begin
        o_errors     = 0;
        o_results    = 0;
        o_degenerate = 0;
    end

endmodule

>>> verif/least_squares_track_line_fit_tb.sv
`timescale 1ns / 1ps

module least_squares_track_line_fit_tb;

    localparam logic signed [23:0] C_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] C_MIN = -24'sh800000;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending, results, degenerate;
    int   points_sent, tracks_sent, long_tracks;
    logic idle_on;
    logic want_hold;
    logic hold_done;
    int   hold_left;

    lstf_point_if #(.COORD_WIDTH(24)) pt_if ();
    lstf_result_if res_if ();

    least_squares_track_line_fit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_point  (pt_if),
        .o_result (res_if)
    );

    lstf_fit_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .pt           (pt_if),
        .res          (res_if),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_results    (results),
        .o_degenerate (degenerate)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // Offer one point and hold it until the block takes it.
    task automatic send_point(logic signed [23:0] x, logic signed [23:0] y,
                              logic signed [23:0] z, logic ux, logic uy, logic last);
        while (idle_on && $urandom_range(99) < 25) begin
            pt_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_if.valid      <= 1'b1;
        pt_if.coord_x    <= x;
        pt_if.coord_y    <= y;
        pt_if.coord_z    <= z;
        pt_if.use_for_xz <= ux;
        pt_if.use_for_yz <= uy;
        pt_if.last_point <= last;
        do @(posedge i_clk); while (!pt_if.ready);
        points_sent++;
        if (last) tracks_sent++;
    endtask

    // One random track. Style 0: full-range noise; 1: a noisy line;
    // 2: every z the same.
    task automatic send_track(int len, int style);
        logic signed [23:0] x, y, z, z0, x0, y0;
        int                 dz, dx, dy, noise;
        logic               ux, uy;
        z0    = 24'($urandom);
        x0    = 24'($urandom);
        y0    = 24'($urandom);
        dz    = $urandom_range(1, 4000) - 2000;
        dx    = $urandom_range(0, 8000) - 4000;
        dy    = $urandom_range(0, 8000) - 4000;
        noise = 1 << $urandom_range(0, 10);
        for (int i = 0; i < len; i++) begin
            if (style == 0) begin
                x = 24'($urandom); y = 24'($urandom); z = 24'($urandom);
            end else begin
                z = (style == 2) ? z0 : 24'(z0 + i * dz);
                x = 24'(x0 + i * dx + $urandom_range(0, noise) - noise / 2);
                y = 24'(y0 + i * dy + $urandom_range(0, noise) - noise / 2);
            end
            ux = ($urandom_range(9) < 8);
            uy = ($urandom_range(9) < 8);
            send_point(x, y, z, ux, uy, i == len - 1);
        end
    endtask

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        res_if.ready <= 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (want_hold && !hold_done) begin
                hold_left = 4000;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= !(idle_on && $urandom_range(99) < 25);
            end
        end
    end

    initial begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int wait_cycles;
        pt_if.valid      <= 1'b0;
        pt_if.coord_x    <= '0;
        pt_if.coord_y    <= '0;
        pt_if.coord_z    <= '0;
        pt_if.use_for_xz <= 1'b0;
        pt_if.use_for_yz <= 1'b0;
        pt_if.last_point <= 1'b0;
        i_rst_n     <= 1'b0;
        idle_on     = 1'b1;
        want_hold   = 1'b0;
        points_sent = 0;
        tracks_sent = 0;
        long_tracks = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: single point, empty fits, equal z.
        send_point(C_MAX, C_MIN, C_MAX, 1'b1, 1'b1, 1'b1);
        send_point(24'sd5, 24'sd7, 24'sd9, 1'b0, 1'b0, 1'b1);
        send_point(24'sd100, 24'sd3, 24'sd50, 1'b1, 1'b1, 1'b0);
        send_point(-24'sd100, 24'sd9, 24'sd50, 1'b1, 1'b1, 1'b1);
        // Steep slopes that saturate both ways.
        send_point(C_MIN, C_MAX, 24'sd0, 1'b1, 1'b1, 1'b0);
        send_point(C_MAX, C_MIN, 24'sd1, 1'b1, 1'b1, 1'b1);
        // Far-off z pushes the intercept out of range.
        send_point(C_MAX, C_MIN, C_MAX, 1'b1, 1'b1, 1'b0);
        send_point(C_MIN, C_MAX, C_MAX - 24'sd1, 1'b1, 1'b1, 1'b1);
        // Extremes of all fields together.
        send_point(C_MIN, C_MIN, C_MIN, 1'b1, 1'b1, 1'b0);
        send_point(C_MAX, C_MAX, C_MAX, 1'b1, 1'b1, 1'b0);
        send_point(24'sd0, 24'sd0, 24'sd0, 1'b1, 1'b1, 1'b1);
        // Half-unit intercept: rounds away from zero.
        send_point(24'sd0, 24'sd0, 24'sd1, 1'b1, 1'b1, 1'b0);
        send_point(24'sd1, -24'sd1, 24'sd3, 1'b1, 1'b1, 1'b1);
        // Points split between the two fits.
        send_point(24'sd10, 24'sd20, 24'sd1, 1'b1, 1'b0, 1'b0);
        send_point(24'sd30, 24'sd40, 24'sd2, 1'b0, 1'b1, 1'b0);
        send_point(24'sd50, 24'sd60, 24'sd3, 1'b1, 1'b0, 1'b0);
        send_point(24'sd70, 24'sd80, 24'sd4, 1'b0, 1'b1, 1'b0);
        send_point(24'sd90, -24'sd5, 24'sd5, 1'b1, 1'b1, 1'b1);

        // Random tracks, mostly short lines; a few overrun the point limit.
        while (points_sent < 1450) begin
            idle_on   = !(points_sent >= 600 && points_sent < 900);
            want_hold = (points_sent >= 250);
            if ($urandom_range(39) == 0) begin
                long_tracks++;
                send_track($urandom_range(126, 140), 1);
            end else begin
                send_track($urandom_range(1, 12), $urandom_range(9) < 7 ? 1 :
                           ($urandom_range(1) ? 0 : 2));
            end
        end
        pt_if.valid <= 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 200_000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (1000) @(posedge i_clk);

        $display("Sent %0d points in %0d tracks (%0d near or past the point limit).",
                 points_sent, tracks_sent, long_tracks);
        $display("Checked %0d fit results, %0d with a degenerate fit.", results, degenerate);
        if (errors == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
